// ===== src/flfa_pkg.sv =====
package flfa_pkg;

   localparam int MEM_SIZE_DEF  = 4096;
   localparam int MAX_SEG_DEF   = 64;
   localparam int HDR_BYTES     = 4;
   localparam int SIZE_W        = 16;
   localparam int ADDR_W        = 13;
   localparam int TOTAL_W       = SIZE_W + 1;
   localparam int STATUS_W      = 2;
   localparam int POLICY_W      = 2;

   typedef enum logic [0:0] {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_INVALID = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [POLICY_W-1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2,
      POL_ALIAS = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DROP
   } cell_op_type;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_A_SCAN,
      FSM_A_APPLY,
      FSM_R_HDR,
      FSM_R_CHECK,
      FSM_R_SCAN,
      FSM_R_APPLY,
      FSM_R_DROP,
      FSM_RESP
   } fsm_type;

endpackage

// ===== src/flfa_if.sv =====
interface flfa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [flfa_pkg::SIZE_W-1:0]   request_size;
   logic [flfa_pkg::ADDR_W-1:0]   block_address;
   modport source (output valid, cmd, request_size, block_address, input ready);
   modport sink (input valid, cmd, request_size, block_address, output ready);
endinterface

interface flfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [flfa_pkg::STATUS_W-1:0] status;
   logic [flfa_pkg::ADDR_W-1:0]   alloc_address;
   modport source (output valid, status, alloc_address, input ready);
   modport sink (input valid, status, alloc_address, output ready);
endinterface

// ===== src/flfa_cell.sv =====
module flfa_cell #(
   parameter int LEN_W     = 13,
   parameter int IDX_W     = 6,
   parameter int INDEX     = 0,
   parameter int RESET_LEN = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  flfa_pkg::cell_op_type     op,
   input  logic [IDX_W-1:0]          target,
   input  logic [LEN_W-1:0]          wr_start,
   input  logic [LEN_W-1:0]          wr_len,
   input  logic [LEN_W-1:0]          left_start,
   input  logic [LEN_W-1:0]          left_len,
   input  logic [LEN_W-1:0]          right_start,
   input  logic [LEN_W-1:0]          right_len,
   output logic [LEN_W-1:0]          start,
   output logic [LEN_W-1:0]          len
);
   import flfa_pkg::*;

   localparam logic [IDX_W-1:0] K = IDX_W'(INDEX);

   logic [LEN_W-1:0] start_ff, start_in, len_ff, len_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      unique case (op)
         CELL_HOLD: begin
         end
         CELL_WRITE: begin
            if (K == target) begin
               start_in = wr_start;
               len_in   = wr_len;
            end
         end
         CELL_INSERT: begin
            if (K == target) begin
               start_in = wr_start;
               len_in   = wr_len;
            end else if (K > target) begin
               start_in = left_start;
               len_in   = left_len;
            end
         end
         CELL_DROP: begin
            if (K >= target) begin
               start_in = right_start;
               len_in   = right_len;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= (INDEX == 0) ? LEN_W'(RESET_LEN) : '0;
      end else begin
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   assign start = start_ff;
   assign len   = len_ff;

endmodule

// ===== src/flfa_hdr_store.sv =====
module flfa_hdr_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 14
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/free_list_fit_allocator_core.sv =====
// free list allocator over an arena of MEM_SIZE bytes
// req channel: cmd 0 allocates request_size bytes (plus a 4-byte header),
// cmd 1 releases the block at block_address. one rsp transfer per req
// transfer, carrying status and alloc_address (0 unless an allocate is ok).
// csr_write_enable/csr_write_data set the fit policy (0 first, 1 best,
// 2 or 3 next fit); write it only while no request is in flight.
// free segments sit in a row of cells, one per list entry; inserts and
// drops shift the whole row together, the scan walks it one entry per
// cycle. allocate scans, then writes the header; release checks the
// header, scans the entries below the address, then merges or inserts.
// one request is handled at a time: req_ch.ready is high only when idle.
// after reset the header store is swept with req_ch.ready low; csr
// writes are still taken. when rsp_ch.ready is low the result is
// held and no new request is taken until its transfer.
module free_list_fit_allocator_core #(
   parameter int MEM_SIZE     = flfa_pkg::MEM_SIZE_DEF,
   parameter int MAX_SEGMENTS = flfa_pkg::MAX_SEG_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   flfa_req_if.sink                      req_ch,
   flfa_rsp_if.source                    rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [flfa_pkg::POLICY_W-1:0] csr_write_data
);
   import flfa_pkg::*;

   localparam int LEN_W = $clog2(MEM_SIZE + 1);
   localparam int HA_W  = $clog2(MEM_SIZE);
   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   fsm_type            state_ff, state_in;
   policy_type         policy_ff, policy_in;
   logic [CNT_W-1:0]   count_ff, count_in, idx_ff, idx_in, p_ff, p_in;
   logic [IDX_W-1:0]   nfp_ff, nfp_in, pick_ff, pick_in;
   logic [HA_W-1:0]    clr_ff, clr_in, a_ff, a_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]   pick_start_ff, pick_start_in, pick_len_ff, pick_len_in;
   logic [LEN_W:0]     best_ff, best_in, prev_end_ff, prev_end_in;
   logic               found_ff, found_in, prev_adj_ff, prev_adj_in;
   logic               next_adj_ff, next_adj_in;
   logic [LEN_W-1:0]   used_ff, used_in, prev_start_ff, prev_start_in;
   logic [LEN_W-1:0]   prev_len_ff, prev_len_in, cur_len_ff, cur_len_in;
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   cell_op_type        cop;
   logic [IDX_W-1:0]   ctgt;
   logic [LEN_W-1:0]   cw_start, cw_len;
   logic [LEN_W-1:0]   c_start [MAX_SEGMENTS];
   logic [LEN_W-1:0]   c_len   [MAX_SEGMENTS];
   logic [LEN_W-1:0]   rd_start, rd_len;

   logic               hw_we;
   logic [HA_W-1:0]    hw_addr;
   logic [LEN_W:0]     hw_data, hr_data;

   logic               in_range, fits;
   logic [LEN_W-1:0]   aw;
   logic [CNT_W-1:0]   pm1;
   logic [TOTAL_W-1:0] rel_a;
   logic               finish;

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      logic [LEN_W-1:0] ls, ll, rs, rl;
      if (k == 0) begin : g_first
         assign ls = '0;
         assign ll = '0;
      end else begin : g_mid
         assign ls = c_start[k-1];
         assign ll = c_len[k-1];
      end
      if (k == MAX_SEGMENTS - 1) begin : g_last
         assign rs = '0;
         assign rl = '0;
      end else begin : g_body
         assign rs = c_start[k+1];
         assign rl = c_len[k+1];
      end
      flfa_cell #(
         .LEN_W(LEN_W), .IDX_W(IDX_W), .INDEX(k), .RESET_LEN(MEM_SIZE)
      ) u_cell (
         .clock(clock), .reset(reset), .op(cop), .target(ctgt),
         .wr_start(cw_start), .wr_len(cw_len),
         .left_start(ls), .left_len(ll), .right_start(rs), .right_len(rl),
         .start(c_start[k]), .len(c_len[k])
      );
   end

   always_comb begin
      rd_start = '0;
      rd_len   = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         if (idx_ff[IDX_W-1:0] == IDX_W'(k)) begin
            rd_start = rd_start | c_start[k];
            rd_len   = rd_len | c_len[k];
         end
      end
   end

   flfa_hdr_store #(.DEPTH(MEM_SIZE), .AW(HA_W), .DW(LEN_W + 1)) u_hdr (
      .clock(clock), .we(hw_we), .waddr(hw_addr), .wdata(hw_data),
      .raddr(a_ff), .rdata(hr_data)
   );

   assign in_range = idx_ff < count_ff;
   assign fits     = TOTAL_W'(rd_len) >= total_ff;
   assign aw       = LEN_W'(a_ff);
   assign pm1      = p_ff - CNT_W'(1);
   assign rel_a    = TOTAL_W'(req_ch.block_address) - TOTAL_W'(HDR_BYTES);

   assign req_ch.ready         = (state_ff == FSM_IDLE);
   assign rsp_ch.valid         = (state_ff == FSM_RESP);
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.alloc_address = addr_ff;

   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      p_in          = p_ff;
      nfp_in        = nfp_ff;
      pick_in       = pick_ff;
      clr_in        = clr_ff;
      a_in          = a_ff;
      total_in      = total_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      best_in       = best_ff;
      prev_end_in   = prev_end_ff;
      found_in      = found_ff;
      prev_adj_in   = prev_adj_ff;
      next_adj_in   = next_adj_ff;
      used_in       = used_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      cur_len_in    = cur_len_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      cop           = CELL_HOLD;
      ctgt          = pick_ff;
      cw_start      = '0;
      cw_len        = '0;
      hw_we         = 1'b0;
      hw_addr       = a_ff;
      hw_data       = '0;
      finish        = 1'b0;

      if (csr_write_enable) begin
         policy_in = (csr_write_data == POL_ALIAS) ? POL_NEXT : policy_type'(csr_write_data);
      end

      unique case (state_ff)
         FSM_CLEAR: begin
            hw_we   = 1'b1;
            hw_addr = clr_ff;
            clr_in  = clr_ff + HA_W'(1);
            if (clr_ff == HA_W'(MEM_SIZE - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_ch.valid) begin
               addr_in = '0;
               if (req_ch.cmd == CMD_ALLOC) begin
                  total_in = TOTAL_W'(req_ch.request_size) + TOTAL_W'(HDR_BYTES);
                  best_in  = '1;
                  found_in = 1'b0;
                  idx_in   = (policy_ff == POL_NEXT) ? CNT_W'(nfp_ff) : '0;
                  state_in = FSM_A_SCAN;
               end else if (req_ch.block_address < ADDR_W'(HDR_BYTES) ||
                            rel_a >= TOTAL_W'(MEM_SIZE)) begin
                  status_in = ST_INVALID;
                  state_in  = FSM_RESP;
               end else begin
                  a_in     = HA_W'(rel_a);
                  state_in = FSM_R_HDR;
               end
            end
         end
         FSM_A_SCAN: begin
            if (!in_range) begin
               if (found_ff) begin
                  state_in = FSM_A_APPLY;
               end else begin
                  status_in = ST_NOFIT;
                  state_in  = FSM_RESP;
               end
            end else if (policy_ff == POL_BEST) begin
               if (fits && {1'b0, rd_len} < best_ff) begin
                  found_in      = 1'b1;
                  pick_in       = idx_ff[IDX_W-1:0];
                  pick_start_in = rd_start;
                  pick_len_in   = rd_len;
                  best_in       = {1'b0, rd_len};
               end
               idx_in = idx_ff + CNT_W'(1);
            end else if (fits) begin
               found_in      = 1'b1;
               pick_in       = idx_ff[IDX_W-1:0];
               pick_start_in = rd_start;
               pick_len_in   = rd_len;
               if (policy_ff == POL_NEXT) begin
                  nfp_in = idx_ff[IDX_W-1:0];
               end
               state_in = FSM_A_APPLY;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         FSM_A_APPLY: begin
            hw_we   = 1'b1;
            hw_addr = HA_W'(pick_start_ff);
            hw_data = {1'b1, total_ff[LEN_W-1:0]};
            ctgt    = pick_ff;
            if (total_ff == TOTAL_W'(pick_len_ff)) begin
               cop      = CELL_DROP;
               count_in = count_ff - CNT_W'(1);
            end else begin
               cop      = CELL_WRITE;
               cw_start = pick_start_ff + total_ff[LEN_W-1:0];
               cw_len   = pick_len_ff - total_ff[LEN_W-1:0];
            end
            status_in = ST_OK;
            addr_in   = ADDR_W'(TOTAL_W'(pick_start_ff) + TOTAL_W'(HDR_BYTES));
            state_in  = FSM_RESP;
         end
         FSM_R_HDR: begin
            state_in = FSM_R_CHECK;
         end
         FSM_R_CHECK: begin
            if (!hr_data[LEN_W] || hr_data[LEN_W-1:0] <= LEN_W'(HDR_BYTES)) begin
               status_in = ST_INVALID;
               state_in  = FSM_RESP;
            end else begin
               used_in     = hr_data[LEN_W-1:0];
               idx_in      = '0;
               prev_end_in = '0;
               state_in    = FSM_R_SCAN;
            end
         end
         FSM_R_SCAN: begin
            if (in_range && rd_start < aw) begin
               prev_start_in = rd_start;
               prev_len_in   = rd_len;
               prev_end_in   = {1'b0, rd_start} + {1'b0, rd_len};
               idx_in        = idx_ff + CNT_W'(1);
            end else begin
               p_in        = idx_ff;
               cur_len_in  = rd_len;
               next_adj_in = in_range && ({1'b0, aw} + {1'b0, used_ff}) == {1'b0, rd_start};
               prev_adj_in = (idx_ff != '0) && (prev_end_ff == {1'b0, aw});
               state_in    = FSM_R_APPLY;
            end
         end
         FSM_R_APPLY: begin
            if (prev_adj_ff && next_adj_ff) begin
               cop      = CELL_WRITE;
               ctgt     = pm1[IDX_W-1:0];
               cw_start = prev_start_ff;
               cw_len   = prev_len_ff + used_ff + cur_len_ff;
               state_in = FSM_R_DROP;
            end else if (prev_adj_ff) begin
               cop      = CELL_WRITE;
               ctgt     = pm1[IDX_W-1:0];
               cw_start = prev_start_ff;
               cw_len   = prev_len_ff + used_ff;
               finish   = 1'b1;
            end else if (next_adj_ff) begin
               cop      = CELL_WRITE;
               ctgt     = p_ff[IDX_W-1:0];
               cw_start = aw;
               cw_len   = cur_len_ff + used_ff;
               finish   = 1'b1;
            end else if (count_ff >= CNT_W'(MAX_SEGMENTS)) begin
               status_in = ST_FULL;
               state_in  = FSM_RESP;
            end else begin
               cop      = CELL_INSERT;
               ctgt     = p_ff[IDX_W-1:0];
               cw_start = aw;
               cw_len   = used_ff;
               count_in = count_ff + CNT_W'(1);
               finish   = 1'b1;
            end
         end
         FSM_R_DROP: begin
            cop      = CELL_DROP;
            ctgt     = p_ff[IDX_W-1:0];
            count_in = count_ff - CNT_W'(1);
            finish   = 1'b1;
         end
         FSM_RESP: begin
            if (rsp_ch.ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (finish) begin
         hw_we     = 1'b1;
         hw_addr   = a_ff;
         hw_data   = '0;
         nfp_in    = '0;
         status_in = ST_OK;
         state_in  = FSM_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_CLEAR;
         policy_ff <= POL_FIRST;
         count_ff  <= CNT_W'(1);
         nfp_ff    <= '0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         policy_ff <= policy_in;
         count_ff  <= count_in;
         nfp_ff    <= nfp_in;
         clr_ff    <= clr_in;
      end
      idx_ff        <= idx_in;
      p_ff          <= p_in;
      pick_ff       <= pick_in;
      a_ff          <= a_in;
      total_ff      <= total_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
      best_ff       <= best_in;
      prev_end_ff   <= prev_end_in;
      found_ff      <= found_in;
      prev_adj_ff   <= prev_adj_in;
      next_adj_ff   <= next_adj_in;
      used_ff       <= used_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      cur_len_ff    <= cur_len_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count above list size");

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && status_ff != ST_OK |-> addr_ff == '0)
      else $error("nonzero address on a failed request");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cop == CELL_INSERT |-> count_ff < CNT_W'(MAX_SEGMENTS))
      else $error("insert into a full list");
`endif

endmodule

// ===== verif/free_list_fit_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module free_list_fit_allocator_core_tb;
   import flfa_pkg::*;

   localparam int MEM_SIZE     = MEM_SIZE_DEF;
   localparam int MAX_SEGMENTS = MAX_SEG_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = MAX_SEGMENTS + 16;

   typedef struct {
      status_type      status;
      logic [ADDR_W-1:0] addr;
   } alloc_result_type;

   class arena_scoreboard;
      int seg_start[MAX_SEGMENTS];
      int seg_len[MAX_SEGMENTS];
      int seg_count;
      int next_ptr;
      bit hdr_valid[MEM_SIZE];
      int hdr_used[MEM_SIZE];
      policy_type policy;
      alloc_result_type pending_q[$];
      int live_blocks[$];
      int errors;
      int n_status[4];

      function void reset_arena();
         foreach (hdr_valid[i]) begin
            hdr_valid[i] = 0;
            hdr_used[i] = 0;
         end
         seg_start[0] = 0;
         seg_len[0] = MEM_SIZE;
         seg_count = 1;
         next_ptr = 0;
         policy = POL_FIRST;
         errors = 0;
      endfunction

      function void set_policy(policy_type p);
         policy = (p == POL_ALIAS) ? POL_NEXT : p;
      endfunction

      function void drop_seg(int k);
         for (int j = k; j + 1 < seg_count; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j] = seg_len[j+1];
         end
         seg_count--;
      endfunction

      function alloc_result_type do_alloc(int req);
         alloc_result_type r;
         int total, pick, best;
         bit found;
         total = req + HDR_BYTES;
         pick = 0;
         best = 32'h7fffffff;
         found = 0;
         r.status = ST_NOFIT;
         r.addr = '0;
         if (policy == POL_FIRST) begin
            for (int i = 0; i < seg_count && !found; i++)
               if (total <= seg_len[i]) begin
                  found = 1;
                  pick = i;
               end
         end else if (policy == POL_BEST) begin
            for (int i = 0; i < seg_count; i++)
               if (total <= seg_len[i] && seg_len[i] < best) begin
                  found = 1;
                  pick = i;
                  best = seg_len[i];
               end
         end else begin
            for (int i = next_ptr; i < seg_count && !found; i++)
               if (total <= seg_len[i]) begin
                  found = 1;
                  pick = i;
                  next_ptr = i;
               end
         end
         if (found) begin
            int s;
            s = seg_start[pick];
            hdr_valid[s] = 1;
            hdr_used[s] = total;
            if (total == seg_len[pick]) drop_seg(pick);
            else begin
               seg_start[pick] = s + total;
               seg_len[pick] -= total;
            end
            r.status = ST_OK;
            r.addr = ADDR_W'(s + HDR_BYTES);
            if (total > HDR_BYTES) live_blocks.insert(live_blocks.size(), s + HDR_BYTES);
         end
         return r;
      endfunction

      function alloc_result_type do_release(int uaddr);
         alloc_result_type r;
         int a, used, p;
         bit prev_adj, next_adj;
         r.status = ST_INVALID;
         r.addr = '0;
         if (uaddr < HDR_BYTES) return r;
         a = uaddr - HDR_BYTES;
         if (a >= MEM_SIZE) return r;
         if (!hdr_valid[a] || hdr_used[a] <= HDR_BYTES) return r;
         used = hdr_used[a];
         p = 0;
         while (p < seg_count && seg_start[p] < a) p++;
         prev_adj = p > 0 && seg_start[p-1] + seg_len[p-1] == a;
         next_adj = p < seg_count && a + used == seg_start[p];
         if (prev_adj && next_adj) begin
            seg_len[p-1] += used + seg_len[p];
            drop_seg(p);
         end else if (prev_adj) begin
            seg_len[p-1] += used;
         end else if (next_adj) begin
            seg_start[p] = a;
            seg_len[p] += used;
         end else begin
            if (seg_count >= MAX_SEGMENTS) begin
               r.status = ST_FULL;
               return r;
            end
            for (int j = seg_count; j > p; j--) begin
               seg_start[j] = seg_start[j-1];
               seg_len[j] = seg_len[j-1];
            end
            seg_start[p] = a;
            seg_len[p] = used;
            seg_count++;
         end
         hdr_valid[a] = 0;
         hdr_used[a] = 0;
         next_ptr = 0;
         r.status = ST_OK;
         foreach (live_blocks[i])
            if (live_blocks[i] == uaddr) begin
               live_blocks.delete(i);
               break;
            end
         return r;
      endfunction

      function void note_request(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
         alloc_result_type r;
         if (cmd == CMD_ALLOC) r = do_alloc(int'(size));
         else r = do_release(int'(addr));
         n_status[r.status]++;
         pending_q.insert(pending_q.size(), r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr);
         alloc_result_type e;
         if (pending_q.size() == 0) begin
            $error("unexpected result transfer: status %0d alloc_address %0d", status, addr);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (status !== e.status) begin
            $error("status mismatch: expected %0d actual %0d", e.status, status);
            errors++;
         end
         if (addr !== e.addr) begin
            $error("alloc_address mismatch: expected %0d actual %0d", e.addr, addr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [POLICY_W-1:0] csr_write_data = '0;

   flfa_req_if req_ch();
   flfa_rsp_if rsp_ch();

   arena_scoreboard sb;
   int cycle_count = 0;
   int rsp_stall = 0;
   bit long_hold = 0;
   bit no_idle = 0;
   int items_sent = 0;

   free_list_fit_allocator_core DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = 0;
      req_ch.request_size = '0;
      req_ch.block_address = '0;
      sb = new();
      sb.reset_arena();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.cmd, req_ch.request_size, req_ch.block_address);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.status, rsp_ch.alloc_address);
         if (long_hold) begin
            rsp_stall = 400;
            long_hold = 0;
         end else if (no_idle) rsp_stall = 0;
         else rsp_stall = $urandom_range(0, 7);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (rsp_stall > 0) begin
         rsp_ch.ready <= 0;
         rsp_stall--;
      end else rsp_ch.ready <= 1;
   end

   task automatic send(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= cmd;
      req_ch.request_size <= size;
      req_ch.block_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(policy_type p);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= p;
      sb.set_policy(p);
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic release_live(int idx);
      send(CMD_RELEASE, '0, ADDR_W'(sb.live_blocks[idx]));
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (sb.live_blocks.size() == 0 || r < 55) begin
         r = $urandom_range(0, 99);
         if (r < 75) send(CMD_ALLOC, SIZE_W'($urandom_range(0, 60)), ADDR_W'($urandom));
         else if (r < 88) send(CMD_ALLOC, SIZE_W'($urandom_range(0, 1000)), ADDR_W'($urandom));
         else if (r < 94) send(CMD_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom));
         else send(CMD_ALLOC, SIZE_W'($urandom_range(2000, 4092)), '0);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 82) release_live($urandom_range(0, sb.live_blocks.size() - 1));
         else if (r < 92) send(CMD_RELEASE, SIZE_W'($urandom), ADDR_W'($urandom));
         else send(CMD_RELEASE, '0,
                   ADDR_W'(sb.live_blocks[0] + $urandom_range(1, 8)));
      end
   endtask

   initial begin
      policy_type pols[4];
      int seg_max;
      pols = '{POL_FIRST, POL_BEST, POL_NEXT, POL_ALIAS};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed
      write_policy(POL_FIRST);
      send(CMD_ALLOC, 16'd0, '0);
      send(CMD_RELEASE, '0, 13'd4);
      send(CMD_ALLOC, 16'd100, 13'h1fff);
      send(CMD_ALLOC, 16'd200, '0);
      send(CMD_ALLOC, 16'd50, '0);
      send(CMD_RELEASE, 16'hffff, 13'd0);
      send(CMD_RELEASE, '0, 13'd3);
      send(CMD_RELEASE, '0, 13'd4100);
      send(CMD_RELEASE, '0, 13'h1fff);
      send(CMD_ALLOC, 16'hffff, '0);
      send(CMD_RELEASE, '0, 13'd8);
      send(CMD_RELEASE, '0, 13'd8);
      send(CMD_ALLOC, 16'd20, '0);
      send(CMD_RELEASE, '0, 13'd112);
      seg_max = sb.seg_len[sb.seg_count - 1];
      send(CMD_ALLOC, SIZE_W'(seg_max - HDR_BYTES), '0);
      send(CMD_ALLOC, 16'd1, '0);
      send(CMD_ALLOC, 16'd4092, '0);
      while (sb.live_blocks.size() > 0) release_live(0);
      send(CMD_ALLOC, 16'd4092, '0);
      send(CMD_RELEASE, '0, 13'd4);

      // allocate small blocks back to back, then release addresses inside them
      no_idle = 1;
      for (int i = 0; i < 140; i++) send(CMD_ALLOC, 16'd4, '0);
      no_idle = 0;
      long_hold = 1;
      for (int i = 0; i < 140; i += 2) send(CMD_RELEASE, '0, ADDR_W'(i * 8 + 2 * HDR_BYTES));
      wait_idle();

      foreach (pols[k]) begin
         write_policy(pols[k]);
         while (sb.live_blocks.size() > 40) release_live($urandom_range(0, 39));
         no_idle = (k == 2);
         for (int i = 0; i < 60; i++) random_item();
         no_idle = 0;
      end

      wait_idle();
      $display("ran %0d requests over all fit policies: %0d ok, %0d no fit, %0d invalid, %0d full",
               items_sent, sb.n_status[ST_OK], sb.n_status[ST_NOFIT],
               sb.n_status[ST_INVALID], sb.n_status[ST_FULL]);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
